FILE: src/plc_pkg.sv
`timescale 1ns / 1ps
package plc_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_CAPACITY = 64;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;
  localparam int STAT_W = 2;
  localparam int IDX_W = $clog2(MAX_CAPACITY);

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_LIST_ALL  = 3'd6
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    FSM_RUN,
    FSM_LIST
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

endpackage

FILE: src/plc_cell.sv
`timescale 1ns / 1ps
module plc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                              clk,
  input  plc_pkg::cell_cmd_t                cmd,
  input  logic signed [plc_pkg::DATA_W-1:0] new_val,
  input  logic signed [plc_pkg::DATA_W-1:0] lower_val,
  input  logic signed [plc_pkg::DATA_W-1:0] upper_val,
  output logic signed [plc_pkg::DATA_W-1:0] val
);
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (cmd.mode)
      CELL_INSERT: begin
        if (MY_IDX == cmd.idx) begin
          val_next = new_val;
        end else if (MY_IDX > cmd.idx) begin
          val_next = lower_val;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= cmd.idx) begin
          val_next = upper_val;
        end
      end
      CELL_ROTATE: begin
        if (MY_IDX == cmd.idx) begin
          val_next = new_val;
        end else if (MY_IDX < cmd.idx) begin
          val_next = upper_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: src/positional_list_store_top.sv
`timescale 1ns / 1ps
// The list lives in a row of cells, one element per cell, front element in cell zero. An insert
// or delete shifts every affected cell toward its neighbor at once, so those operations are taken
// at one per clock whenever no list_all is in progress and the output register is free or being
// drained. A list_all beat produces one result per stored element, one per cycle while the output
// register is free or being drained, by rotating the row through cell zero; the accepting cycle
// loads no result unless the list is empty, when it loads the only result, and no new beat is taken
// until the last result has entered the output register. Every other operation produces one result.
module positional_list_store_top #(
  parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plc_pkg::KIND_W-1:0]        kind,
  input  logic signed [plc_pkg::DATA_W-1:0] value,
  input  logic [plc_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [plc_pkg::STAT_W-1:0]        status,
  output logic [plc_pkg::CNT_W-1:0]         count,
  output logic signed [plc_pkg::DATA_W-1:0] item_value,
  output logic                              item_valid,
  output logic                              last
);
  import plc_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  fsm_t                     state;
  fsm_t                     state_next;
  logic [CNT_W-1:0]         count_reg;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         list_idx;
  logic [IDX_W-1:0]         list_idx_next;
  logic                     slot_free;
  logic                     in_acc;
  logic                     list_last;
  logic                     full;
  logic                     ins_pos_ok;
  logic                     del_pos_ok;
  logic [IDX_W-1:0]         pos_idx;
  logic [IDX_W-1:0]         cnt_idx;
  logic [IDX_W-1:0]         last_idx;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] new_val;
  logic                     ld;
  status_t                  ld_status;
  logic signed [DATA_W-1:0] ld_item;
  logic                     ld_ivalid;
  logic                     ld_last;
  logic signed [DATA_W-1:0] cells [CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] lower_val;
      logic signed [DATA_W-1:0] upper_val;
      if (g == 0) begin : g_lo
        assign lower_val = '0;
      end else begin : g_lo
        assign lower_val = cells[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
        assign upper_val = '0;
      end else begin : g_hi
        assign upper_val = cells[g+1];
      end
      plc_cell #(
        .CELL_IDX(g)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .new_val  (new_val),
        .lower_val(lower_val),
        .upper_val(upper_val),
        .val      (cells[g])
      );
    end
  endgenerate

  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == FSM_RUN) && slot_free;
  assign in_acc     = in_valid && in_ready;
  assign full       = (count_reg >= CAP);
  assign ins_pos_ok = (position != '0) &&
                      ({1'b0, position} <= ({1'b0, count_reg} + (CNT_W + 1)'(1)));
  assign del_pos_ok = (position != '0) && (position <= count_reg);
  assign pos_idx    = IDX_W'(position - POS_W'(1));
  assign cnt_idx    = IDX_W'(count_reg);
  assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
  assign list_last  = ((CNT_W'(list_idx) + CNT_W'(1)) == count_reg);

  always_comb begin
    state_next = state;
    case (state)
      FSM_RUN: begin
        if (in_acc && (kind == KIND_LIST_ALL) && (count_reg != '0)) begin
          state_next = FSM_LIST;
        end
      end
      FSM_LIST: begin
        if (slot_free && list_last) begin
          state_next = FSM_RUN;
        end
      end
      default: begin
        state_next = FSM_RUN;
      end
    endcase
  end

  always_comb begin
    cmd           = '{mode: CELL_HOLD, idx: '0};
    new_val       = value;
    ld            = 1'b0;
    ld_status     = STAT_OK;
    ld_item       = '0;
    ld_ivalid     = 1'b0;
    ld_last       = 1'b1;
    count_next    = count_reg;
    list_idx_next = list_idx;
    case (state)
      FSM_RUN: begin
        if (in_acc) begin
          ld = 1'b1;
          case (kind)
            KIND_INS_FRONT, KIND_INS_BACK: begin
              if (full) begin
                ld_status = STAT_FULL;
              end else begin
                cmd.mode   = CELL_INSERT;
                cmd.idx    = (kind == KIND_INS_FRONT) ? '0 : cnt_idx;
                count_next = count_reg + CNT_W'(1);
              end
            end
            KIND_INS_AT: begin
              if (!ins_pos_ok) begin
                ld_status = STAT_BADPOS;
              end else if (full) begin
                ld_status = STAT_FULL;
              end else begin
                cmd.mode   = CELL_INSERT;
                cmd.idx    = pos_idx;
                count_next = count_reg + CNT_W'(1);
              end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK: begin
              if (count_reg == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                cmd.mode   = CELL_DELETE;
                cmd.idx    = (kind == KIND_DEL_FRONT) ? '0 : last_idx;
                count_next = count_reg - CNT_W'(1);
              end
            end
            KIND_DEL_AT: begin
              if (!del_pos_ok) begin
                ld_status = STAT_BADPOS;
              end else begin
                cmd.mode   = CELL_DELETE;
                cmd.idx    = pos_idx;
                count_next = count_reg - CNT_W'(1);
              end
            end
            KIND_LIST_ALL: begin
              if (count_reg == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                ld            = 1'b0;
                list_idx_next = '0;
              end
            end
            default: begin
              ld_status = STAT_OK;
            end
          endcase
        end
      end
      FSM_LIST: begin
        if (slot_free) begin
          ld            = 1'b1;
          ld_item       = cells[0];
          ld_ivalid     = 1'b1;
          ld_last       = list_last;
          cmd.mode      = CELL_ROTATE;
          cmd.idx       = last_idx;
          new_val       = cells[0];
          list_idx_next = list_idx + IDX_W'(1);
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_RUN;
      count_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_reg <= count_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    list_idx <= list_idx_next;
    if (ld) begin
      status     <= ld_status;
      count      <= count_next;
      item_value <= ld_item;
      item_valid <= ld_ivalid;
      last       <= ld_last;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count_reg <= CAP)
    else $error("Element count exceeds capacity.");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_LIST) |-> (count_reg != '0))
    else $error("Listing an empty list.");

  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_valid) |-> (status == STAT_OK))
    else $error("Listed element carries a non-ok status.");

endmodule
